// ===== hdl/stepper_move_pulse_sequencer_assert.svh =====
// Assertion macros shared by the sequencer RTL.
// Each macro expects a clock named clk and a synchronous reset named rst in scope.
`ifndef STEPPER_MOVE_PULSE_SEQUENCER_ASSERT_SVH
`define STEPPER_MOVE_PULSE_SEQUENCER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SMPS_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SMPS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/smps_pkg.sv =====
// Shared types, codes and constants of the stepper move pulse sequencer.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package smps_pkg;

  // Motor count and field widths.
  localparam int unsigned NUM_MOTORS_DEF = 24;
  localparam int unsigned CFG_DATA_W     = 20;
  localparam int unsigned CFG_INDEX_W    = 2;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] CFG_BASE_HALF   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_TORQUE_GAIN = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_SETTLE      = 2'd2;

  // Configuration reset values.
  localparam logic [15:0] BASE_HALF_RST   = 16'd800;
  localparam logic [9:0]  TORQUE_GAIN_RST = 10'd260;
  localparam logic [19:0] SETTLE_RST      = 20'd100000;

  // Input command codes.
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_TICK  = 1'b1;

  // Bus constants.
  localparam logic [6:0] EXP_ADDR_BASE = 7'h20;
  localparam logic [7:0] DIR_FORWARD   = 8'hFF;
  localparam logic [7:0] DIR_REVERSE   = 8'h7F;
  localparam logic [7:0] RELEASE_BYTE  = 8'hFF;
  localparam logic [2:0] MODE_MAX      = 3'd4;

  typedef enum logic [1:0] {
    EV_NONE    = 2'd0,
    EV_SELECT  = 2'd1,
    EV_RELEASE = 2'd2,
    EV_REJECT  = 2'd3
  } event_t;

  typedef enum logic [3:0] {
    PH_IDLE   = 4'b0001,
    PH_SETTLE = 4'b0010,
    PH_HIGH   = 4'b0100,
    PH_LOW    = 4'b1000
  } phase_t;

  // Decoded start beat, handed from the start decoder to the core.
  typedef struct packed {
    logic        ok;
    logic [1:0]  board;
    logic [7:0]  select_byte;
    logic [7:0]  command_byte;
    logic        dir_reverse;
    logic [18:0] half_period;
    logic [15:0] steps;
  } start_t;

  // One result beat.
  typedef struct packed {
    event_t      ev;
    logic [6:0]  addr;
    logic [7:0]  port_a;
    logic [7:0]  port_b;
    logic        pin;
    logic        busy;
  } result_t;

  // Microstep pattern removed from the direction base for each step-size mode.
  function automatic logic [7:0] ms_subtract(input logic [2:0] mode);
    logic [7:0] val;
    case (mode)
      3'd0:    val = 8'h70;
      3'd1:    val = 8'h30;
      3'd2:    val = 8'h50;
      3'd3:    val = 8'h10;
      default: val = 8'h00;
    endcase
    return val;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/smps_start_calc.sv =====
// Start beat decoder: validity check, select and command bytes, half period, step count.
// Depends on smps_pkg.
`timescale 1ns / 1ps
`default_nettype none

module smps_start_calc #(
  parameter int unsigned NUM_MOTORS = smps_pkg::NUM_MOTORS_DEF
) (
  input  wire logic               [4:0]  motor_number,
  input  wire logic               [2:0]  microstep_mode,
  input  wire logic signed        [16:0] step_count,
  input  wire logic               [7:0]  torque,
  input  wire logic               [15:0] base_half_period,
  input  wire logic               [9:0]  torque_gain,
  input  wire logic                      last_dir_reverse,
  output smps_pkg::start_t               start
);

  logic        neg;
  logic [16:0] mag_full;
  logic [4:0]  idx;
  logic [7:0]  dir_base;
  logic [17:0] torque_term;
  logic [18:0] period_sum;

  // Magnitude of the signed count, saturated to 16 bits.
  assign neg      = step_count[16];
  assign mag_full = neg ? (17'd0 - step_count) : step_count;

  // Direction: a zero count keeps the previous one.
  assign start.dir_reverse = (step_count != 17'sd0) ? neg : last_dir_reverse;
  assign dir_base          = start.dir_reverse ? smps_pkg::DIR_REVERSE : smps_pkg::DIR_FORWARD;

  // Motor position: board from the upper bits, active-low select bit from the lower three.
  assign idx               = motor_number - 5'd1;
  assign start.board       = idx[4:3];
  assign start.select_byte = ~(8'h80 >> idx[2:0]);

  assign start.command_byte = dir_base - smps_pkg::ms_subtract(microstep_mode);

  // Half period scaled by the microstep size.
  assign torque_term       = 18'(torque) * 18'(torque_gain);
  assign period_sum        = 19'(base_half_period) + 19'(torque_term);
  assign start.half_period = period_sum >> microstep_mode;

  assign start.steps = mag_full[16] ? 16'hFFFF : mag_full[15:0];

  assign start.ok = (motor_number != 5'd0)
                 && ({1'b0, motor_number} <= 6'(NUM_MOTORS))
                 && (microstep_mode <= smps_pkg::MODE_MAX);

endmodule

`default_nettype wire

// ===== hdl/smps_core.sv =====
// Move state machine: settle wait, step pulses, release write; builds each result beat.
// Depends on smps_pkg and stepper_move_pulse_sequencer_assert.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "stepper_move_pulse_sequencer_assert.svh"

module smps_core (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     go,
  input  wire logic                     cmd,
  input  wire smps_pkg::start_t         start,
  input  wire logic              [19:0] settle_ticks,
  output logic                          last_dir_reverse,
  output smps_pkg::result_t             result
);

  smps_pkg::phase_t phase, phase_next;
  logic [1:0]  board_index, board_index_next;
  logic        last_dir_reverse_next;
  logic [15:0] steps_left, steps_left_next;
  logic [18:0] half_period, half_period_next;
  logic [19:0] tick_counter, tick_counter_next;
  logic        pin_level, pin_level_next;
  logic [18:0] half_m1;
  logic [6:0]  board_addr;

  // Reload value for each pulse half; a zero half period counts as one tick.
  assign half_m1    = (half_period == 19'd0) ? 19'd0 : half_period - 19'd1;
  assign board_addr = smps_pkg::EXP_ADDR_BASE + {4'd0, board_index, 1'b0};

  // Next state and result for the beat on the input side.
  always_comb begin
    phase_next            = phase;
    board_index_next      = board_index;
    last_dir_reverse_next = last_dir_reverse;
    steps_left_next       = steps_left;
    half_period_next      = half_period;
    tick_counter_next     = tick_counter;
    pin_level_next        = pin_level;
    result.ev             = smps_pkg::EV_NONE;
    result.addr           = 7'd0;
    result.port_a         = 8'd0;
    result.port_b         = 8'd0;

    if (cmd == smps_pkg::CMD_START) begin
      if (phase != smps_pkg::PH_IDLE || !start.ok) begin
        result.ev = smps_pkg::EV_REJECT;
      end else begin
        board_index_next      = start.board;
        last_dir_reverse_next = start.dir_reverse;
        steps_left_next       = start.steps;
        half_period_next      = start.half_period;
        tick_counter_next     = settle_ticks;
        pin_level_next        = 1'b0;
        phase_next            = smps_pkg::PH_SETTLE;
        result.ev             = smps_pkg::EV_SELECT;
        result.addr           = smps_pkg::EXP_ADDR_BASE + {4'd0, start.board, 1'b0};
        result.port_a         = start.command_byte;
        result.port_b         = start.select_byte;
      end
    end else begin
      unique case (phase)
        smps_pkg::PH_SETTLE, smps_pkg::PH_LOW: begin
          if (tick_counter != 20'd0) begin
            tick_counter_next = tick_counter - 20'd1;
          end else if (steps_left != 16'd0) begin
            steps_left_next   = steps_left - 16'd1;
            pin_level_next    = 1'b1;
            phase_next        = smps_pkg::PH_HIGH;
            tick_counter_next = 20'(half_m1);
          end else begin
            pin_level_next = 1'b0;
            phase_next     = smps_pkg::PH_IDLE;
            result.ev      = smps_pkg::EV_RELEASE;
            result.addr    = board_addr;
            result.port_a  = smps_pkg::RELEASE_BYTE;
            result.port_b  = smps_pkg::RELEASE_BYTE;
          end
        end
        smps_pkg::PH_HIGH: begin
          if (tick_counter != 20'd0) begin
            tick_counter_next = tick_counter - 20'd1;
          end else begin
            pin_level_next    = 1'b0;
            phase_next        = smps_pkg::PH_LOW;
            tick_counter_next = 20'(half_m1);
          end
        end
        smps_pkg::PH_IDLE: begin
          pin_level_next = 1'b0;
        end
      endcase
    end

    result.pin  = pin_level_next;
    result.busy = (phase_next != smps_pkg::PH_IDLE);
  end

  // State registers advance only on an accepted beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= smps_pkg::PH_IDLE;
      board_index      <= 2'd0;
      last_dir_reverse <= 1'b0;
      steps_left       <= 16'd0;
      half_period      <= 19'd0;
      tick_counter     <= 20'd0;
      pin_level        <= 1'b0;
    end else if (go) begin
      phase            <= phase_next;
      board_index      <= board_index_next;
      last_dir_reverse <= last_dir_reverse_next;
      steps_left       <= steps_left_next;
      half_period      <= half_period_next;
      tick_counter     <= tick_counter_next;
      pin_level        <= pin_level_next;
    end
  end

  // The step pin is only high during the high half of a pulse.
  `SMPS_ASSERT_SAME(a_pin_only_high, pin_level, phase == smps_pkg::PH_HIGH, "step pin high outside high phase")
  // A rejected start leaves the move untouched.
  `SMPS_ASSERT_NEXT(a_reject_keeps, go && result.ev == smps_pkg::EV_REJECT, $stable(phase) && $stable(steps_left) && $stable(tick_counter), "rejected start changed state")
  // A release write always ends the move.
  `SMPS_ASSERT_NEXT(a_release_idle, go && result.ev == smps_pkg::EV_RELEASE, phase == smps_pkg::PH_IDLE && !pin_level, "release did not end the move")
  // A pulse half never counts longer than the latched half period.
  `SMPS_ASSERT_SAME(a_half_bound, phase == smps_pkg::PH_HIGH || phase == smps_pkg::PH_LOW, tick_counter <= 20'(half_period), "pulse counter above half period")

endmodule

`default_nettype wire

// ===== hdl/smps_out_buf.sv =====
// Result register with a skid stage so the input side keeps moving while a beat waits.
// Depends on smps_pkg.
`timescale 1ns / 1ps
`default_nettype none

module smps_out_buf (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              load,
  input  wire smps_pkg::result_t load_data,
  output logic                   full,
  output logic                   res_valid,
  input  wire logic              res_stall,
  output smps_pkg::result_t      res_data
);

  smps_pkg::result_t skid_data;
  logic              skid_valid;
  logic              take;
  logic              load_out;
  logic              load_skid;

  assign take      = res_valid && !res_stall;
  assign load_out  = skid_valid ? take : (load && (!res_valid || take));
  assign load_skid = !skid_valid && load && res_valid && !take;
  assign full      = skid_valid;

  // Valid flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (skid_valid) begin
        skid_valid <= !take;
      end else begin
        skid_valid <= load_skid;
        if (load) begin
          res_valid <= 1'b1;
        end else if (take) begin
          res_valid <= 1'b0;
        end
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (load_out) begin
      res_data <= skid_valid ? skid_data : load_data;
    end
    if (load_skid) begin
      skid_data <= load_data;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/stepper_move_pulse_sequencer.sv =====
// Stepper move pulse sequencer: one move at a time, advanced by one tick beat per cycle
// while item_stall is low. The result of a beat is registered in the output register,
// or in the skid stage while the output stalls; the move state updates as a beat is taken.
// item_stall rises only while the skid stage holds a beat behind a stalled output.
// Reset is synchronous: move state, output valids and config registers return to defaults.
`timescale 1ns / 1ps
`default_nettype none

module stepper_move_pulse_sequencer #(
  parameter int unsigned NUM_MOTORS = smps_pkg::NUM_MOTORS_DEF
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   cfg_write,
  input  wire logic [smps_pkg::CFG_INDEX_W-1:0]       cfg_index,
  input  wire logic [smps_pkg::CFG_DATA_W-1:0]        cfg_data,
  input  wire logic                                   item_valid,
  output logic                                        item_stall,
  input  wire logic                                   cmd,
  input  wire logic                  [4:0]            motor_number,
  input  wire logic                  [2:0]            microstep_mode,
  input  wire logic signed           [16:0]           step_count,
  input  wire logic                  [7:0]            torque,
  output logic                                        res_valid,
  input  wire logic                                   res_stall,
  output logic                       [1:0]            event_res,
  output logic                       [6:0]            expander_address,
  output logic                       [7:0]            port_a_byte,
  output logic                       [7:0]            port_b_byte,
  output logic                                        step_pin,
  output logic                                        busy_res
);

  logic [15:0]       base_half_period;
  logic [9:0]        torque_gain;
  logic [19:0]       settle_ticks;
  logic              go;
  logic              last_dir_reverse;
  smps_pkg::start_t  start;
  smps_pkg::result_t result;
  smps_pkg::result_t res_data;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      base_half_period <= smps_pkg::BASE_HALF_RST;
      torque_gain      <= smps_pkg::TORQUE_GAIN_RST;
      settle_ticks     <= smps_pkg::SETTLE_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        smps_pkg::CFG_BASE_HALF:   base_half_period <= cfg_data[15:0];
        smps_pkg::CFG_TORQUE_GAIN: torque_gain      <= cfg_data[9:0];
        smps_pkg::CFG_SETTLE:      settle_ticks     <= cfg_data;
        default: ;
      endcase
    end
  end

  assign go = item_valid && !item_stall;

  smps_start_calc #(
    .NUM_MOTORS (NUM_MOTORS)
  ) u_start_calc (
    .motor_number     (motor_number),
    .microstep_mode   (microstep_mode),
    .step_count       (step_count),
    .torque           (torque),
    .base_half_period (base_half_period),
    .torque_gain      (torque_gain),
    .last_dir_reverse (last_dir_reverse),
    .start            (start)
  );

  smps_core u_core (
    .clk              (clk),
    .rst              (rst),
    .go               (go),
    .cmd              (cmd),
    .start            (start),
    .settle_ticks     (settle_ticks),
    .last_dir_reverse (last_dir_reverse),
    .result           (result)
  );

  smps_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .load      (go),
    .load_data (result),
    .full      (item_stall),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_data  (res_data)
  );

  // Result beat fields.
  assign event_res        = res_data.ev;
  assign expander_address = res_data.addr;
  assign port_a_byte      = res_data.port_a;
  assign port_b_byte      = res_data.port_b;
  assign step_pin         = res_data.pin;
  assign busy_res         = res_data.busy;

endmodule

`default_nettype wire

// ===== tb/stepper_move_pulse_sequencer_test.sv =====
`timescale 1ns / 1ps
// Testbench of the stepper move pulse sequencer: directed and random moves, every result beat
// checked field by field against a cycle-free predictor. Needs smps_pkg and the sequencer RTL.

module stepper_move_pulse_sequencer_test;
  import smps_pkg::*;

  localparam int unsigned MOTORS       = NUM_MOTORS_DEF;
  localparam int unsigned RANDOM_BEATS = 1250;
  localparam int unsigned TAIL_CYCLES  = 8;
  localparam longint unsigned CYCLE_LIMIT = 2_000_000;

  // Microstep pattern removed from the direction base, indexed by step-size mode.
  localparam logic [7:0] STEP_PATTERN [0:4] = '{8'h70, 8'h30, 8'h50, 8'h10, 8'h00};

  typedef enum logic [1:0] {
    STEP_BEAT,
    STEP_WRITE,
    STEP_DRAIN,
    STEP_PACE
  } plan_kind_t;

  typedef struct {
    plan_kind_t              kind;
    logic                    cmd_bit;
    logic [4:0]              motor;
    logic [2:0]              mode;
    logic signed [16:0]      count;
    logic [7:0]              tq;
    logic [CFG_INDEX_W-1:0]  reg_index;
    logic [CFG_DATA_W-1:0]   reg_value;
    int unsigned             send_gap;
    int unsigned             take_stall;
  } plan_step_t;

  // Block ports.
  logic                   clk;
  logic                   rst = 1'b1;
  logic                   cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic                   item_valid = 1'b0;
  logic                   item_stall;
  logic                   cmd = CMD_TICK;
  logic [4:0]             motor_number = '0;
  logic [2:0]             microstep_mode = '0;
  logic signed [16:0]     step_count = '0;
  logic [7:0]             torque = '0;
  logic                   res_valid;
  logic                   res_stall = 1'b0;
  logic [1:0]             event_res;
  logic [6:0]             expander_address;
  logic [7:0]             port_a_byte;
  logic [7:0]             port_b_byte;
  logic                   step_pin;
  logic                   busy_res;

  // Stimulus plan, predicted results and run bookkeeping.
  plan_step_t  stimulus_plan[$];
  result_t     awaited_results[$];
  int unsigned send_gap_pct = 0;
  int unsigned take_stall_pct = 0;
  logic        plan_exhausted = 1'b0;
  int unsigned planned_beats = 0;
  int unsigned plan_base = BASE_HALF_RST;
  int unsigned plan_gain = TORQUE_GAIN_RST;
  int unsigned plan_settle = SETTLE_RST;
  int unsigned mismatches = 0;
  int unsigned checked_beats = 0;
  int unsigned moves_started = 0;
  int unsigned moves_released = 0;
  int unsigned starts_refused = 0;
  int unsigned step_pulses = 0;
  logic        last_pin = 1'b0;
  longint unsigned cycle_count = 0;

  // Predictor copy of the registers and of the move state.
  logic [15:0] seq_base;
  logic [9:0]  seq_gain;
  logic [19:0] seq_settle;
  phase_t      seq_phase;
  logic [1:0]  seq_board;
  logic [7:0]  seq_select;
  logic [7:0]  seq_command;
  logic        seq_reverse;
  logic [15:0] seq_steps;
  logic [18:0] seq_half;
  logic [19:0] seq_ticks;
  logic        seq_pin;

  stepper_move_pulse_sequencer dut (
    .clk              (clk),
    .rst              (rst),
    .cfg_write        (cfg_write),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .item_valid       (item_valid),
    .item_stall       (item_stall),
    .cmd              (cmd),
    .motor_number     (motor_number),
    .microstep_mode   (microstep_mode),
    .step_count       (step_count),
    .torque           (torque),
    .res_valid        (res_valid),
    .res_stall        (res_stall),
    .event_res        (event_res),
    .expander_address (expander_address),
    .port_a_byte      (port_a_byte),
    .port_b_byte      (port_b_byte),
    .step_pin         (step_pin),
    .busy_res         (busy_res)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Advances the predicted move by one accepted beat and returns the result it causes.
  function automatic result_t predict_sequencer_result(logic c, logic [4:0] m, logic [2:0] md,
                                                       logic signed [16:0] cnt, logic [7:0] tq);
    result_t     r;
    logic [18:0] eff_half;
    logic [18:0] sum;
    logic [16:0] mag;
    logic [4:0]  idx;
    logic [7:0]  dir_base;
    r.ev = EV_NONE;
    r.addr = '0;
    r.port_a = '0;
    r.port_b = '0;
    eff_half = (seq_half == 19'd0) ? 19'd1 : seq_half;
    if (c == CMD_START) begin
      if (seq_phase != PH_IDLE || m < 5'd1 || m > MOTORS || md > MODE_MAX) begin
        r.ev = EV_REJECT;
      end else begin
        // A zero count keeps whatever direction the last nonzero count chose.
        if (cnt != 17'sd0) seq_reverse = cnt[16];
        dir_base = seq_reverse ? DIR_REVERSE : DIR_FORWARD;
        mag = cnt[16] ? (~cnt + 17'd1) : cnt;
        if (mag > 17'h0FFFF) mag = 17'h0FFFF;
        idx = m - 5'd1;
        seq_board = idx[4:3];
        seq_select = ~(8'h80 >> idx[2:0]);
        seq_command = dir_base - STEP_PATTERN[md];
        sum = 19'(seq_base) + 19'(tq) * 19'(seq_gain);
        seq_half = sum >> md;
        seq_steps = mag[15:0];
        seq_ticks = seq_settle;
        seq_pin = 1'b0;
        seq_phase = PH_SETTLE;
        r.ev = EV_SELECT;
        r.addr = EXP_ADDR_BASE + {4'd0, seq_board, 1'b0};
        r.port_a = seq_command;
        r.port_b = seq_select;
      end
    end else begin
      case (seq_phase)
        PH_SETTLE, PH_LOW: begin
          if (seq_ticks != 20'd0) begin
            seq_ticks = seq_ticks - 20'd1;
          end else if (seq_steps != 16'd0) begin
            seq_steps = seq_steps - 16'd1;
            seq_pin = 1'b1;
            seq_phase = PH_HIGH;
            seq_ticks = 20'(eff_half - 19'd1);
          end else begin
            seq_pin = 1'b0;
            seq_phase = PH_IDLE;
            seq_select = RELEASE_BYTE;
            seq_command = RELEASE_BYTE;
            r.ev = EV_RELEASE;
            r.addr = EXP_ADDR_BASE + {4'd0, seq_board, 1'b0};
            r.port_a = RELEASE_BYTE;
            r.port_b = RELEASE_BYTE;
          end
        end
        PH_HIGH: begin
          if (seq_ticks != 20'd0) begin
            seq_ticks = seq_ticks - 20'd1;
          end else begin
            seq_pin = 1'b0;
            seq_phase = PH_LOW;
            seq_ticks = 20'(eff_half - 19'd1);
          end
        end
        default: begin
          seq_pin = 1'b0;
          seq_phase = PH_IDLE;
        end
      endcase
    end
    r.pin = seq_pin;
    r.busy = (seq_phase != PH_IDLE);
    return r;
  endfunction

  task automatic plan_beat(logic c, logic [4:0] m, logic [2:0] md, logic signed [16:0] cnt,
                           logic [7:0] tq);
    plan_step_t s;
    s.kind = STEP_BEAT;
    s.cmd_bit = c;
    s.motor = m;
    s.mode = md;
    s.count = cnt;
    s.tq = tq;
    stimulus_plan.push_back(s);
    planned_beats++;
  endtask

  // Tick beats carry random content in the fields that a tick ignores.
  task automatic plan_ticks(int unsigned n);
    repeat (n) plan_beat(CMD_TICK, 5'($urandom), 3'($urandom), 17'($urandom), 8'($urandom));
  endtask

  task automatic plan_drain();
    plan_step_t s;
    s.kind = STEP_DRAIN;
    stimulus_plan.push_back(s);
  endtask

  task automatic plan_pace(int unsigned send_gap, int unsigned take_stall);
    plan_step_t s;
    s.kind = STEP_PACE;
    s.send_gap = send_gap;
    s.take_stall = take_stall;
    stimulus_plan.push_back(s);
  endtask

  // Registers change only once every predicted result has come back.
  task automatic plan_register(logic [CFG_INDEX_W-1:0] idx, int unsigned val);
    plan_step_t s;
    plan_drain();
    s.kind = STEP_WRITE;
    s.reg_index = idx;
    s.reg_value = CFG_DATA_W'(val);
    stimulus_plan.push_back(s);
    case (idx)
      CFG_BASE_HALF:   plan_base = val;
      CFG_TORQUE_GAIN: plan_gain = val;
      default:         plan_settle = val;
    endcase
  endtask

  // One start followed by enough ticks to finish the move, or fewer when trimmed.
  task automatic plan_move(logic [4:0] m, logic [2:0] md, logic signed [16:0] cnt,
                           logic [7:0] tq, bit busy_start, bit trimmed);
    int unsigned half;
    int unsigned steps;
    int unsigned span;
    int unsigned ticks;
    int unsigned busy_at;
    int          c;
    half = (plan_base + int'(tq) * plan_gain) >> md;
    if (half == 0) half = 1;
    c = int'(cnt);
    steps = (c < 0) ? -c : c;
    if (steps > 65535) steps = 65535;
    span = plan_settle + 1 + 2 * half * steps;
    ticks = trimmed ? $urandom_range(0, span - 1) : span + $urandom_range(0, 3);
    busy_at = $urandom_range(0, span - 1);
    plan_beat(CMD_START, m, md, cnt, tq);
    for (int unsigned i = 0; i < ticks; i++) begin
      if (busy_start && i == busy_at) begin
        plan_beat(CMD_START, 5'($urandom_range(1, MOTORS)), 3'($urandom_range(0, 4)),
                  17'(int'($urandom_range(0, 6)) - 3), 8'($urandom_range(0, 7)));
      end
      plan_ticks(1);
    end
  endtask

  // Driver: hands out the plan one step at a time and predicts each accepted beat.
  always @(posedge clk) begin
    logic       holding;
    logic       launching;
    logic       writing;
    plan_step_t next_step;
    if (rst) begin
      item_valid <= 1'b0;
      cfg_write <= 1'b0;
      seq_base = BASE_HALF_RST;
      seq_gain = TORQUE_GAIN_RST;
      seq_settle = SETTLE_RST;
      seq_phase = PH_IDLE;
      seq_board = '0;
      seq_select = 8'hFF;
      seq_command = 8'hFF;
      seq_reverse = 1'b0;
      seq_steps = '0;
      seq_half = '0;
      seq_ticks = '0;
      seq_pin = 1'b0;
    end else begin
      holding = item_valid && item_stall;
      launching = 1'b0;
      writing = 1'b0;
      if (item_valid && !item_stall) begin
        awaited_results.push_back(predict_sequencer_result(cmd, motor_number, microstep_mode,
                                                           step_count, torque));
      end
      // Pacing changes take effect at once, before the next step is handed out.
      while (stimulus_plan.size() != 0 && stimulus_plan[0].kind == STEP_PACE) begin
        send_gap_pct = stimulus_plan[0].send_gap;
        take_stall_pct = stimulus_plan[0].take_stall;
        void'(stimulus_plan.pop_front());
      end
      if (!holding && stimulus_plan.size() != 0) begin
        next_step = stimulus_plan[0];
        case (next_step.kind)
          STEP_DRAIN: begin
            if (awaited_results.size() == 0) void'(stimulus_plan.pop_front());
          end
          STEP_WRITE: begin
            writing = 1'b1;
            cfg_index <= next_step.reg_index;
            cfg_data <= next_step.reg_value;
            case (next_step.reg_index)
              CFG_BASE_HALF:   seq_base = next_step.reg_value[15:0];
              CFG_TORQUE_GAIN: seq_gain = next_step.reg_value[9:0];
              CFG_SETTLE:      seq_settle = next_step.reg_value;
              default: ;
            endcase
            void'(stimulus_plan.pop_front());
          end
          STEP_BEAT: begin
            if ($urandom_range(0, 99) >= send_gap_pct) begin
              launching = 1'b1;
              cmd <= next_step.cmd_bit;
              motor_number <= next_step.motor;
              microstep_mode <= next_step.mode;
              step_count <= next_step.count;
              torque <= next_step.tq;
              void'(stimulus_plan.pop_front());
            end
          end
          default: ;
        endcase
      end
      item_valid <= holding || launching;
      cfg_write <= writing;
      if (stimulus_plan.size() == 0 && !holding && !launching) plan_exhausted <= 1'b1;
    end
  end

  // Monitor: checks each result beat against the oldest prediction and stalls at random.
  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      res_stall <= 1'b0;
    end else begin
      if (res_valid && !res_stall) begin
        if (awaited_results.size() == 0) begin
          $error("result beat arrived with no prediction waiting");
          mismatches++;
        end else begin
          want = awaited_results.pop_front();
          checked_beats++;
          if (event_res !== want.ev) begin
            $error("event_res: expected %0d, got %0d", want.ev, event_res);
            mismatches++;
          end
          if (expander_address !== want.addr) begin
            $error("expander_address: expected 0x%0h, got 0x%0h", want.addr, expander_address);
            mismatches++;
          end
          if (port_a_byte !== want.port_a) begin
            $error("port_a_byte: expected 0x%0h, got 0x%0h", want.port_a, port_a_byte);
            mismatches++;
          end
          if (port_b_byte !== want.port_b) begin
            $error("port_b_byte: expected 0x%0h, got 0x%0h", want.port_b, port_b_byte);
            mismatches++;
          end
          if (step_pin !== want.pin) begin
            $error("step_pin: expected %0d, got %0d", want.pin, step_pin);
            mismatches++;
          end
          if (busy_res !== want.busy) begin
            $error("busy_res: expected %0d, got %0d", want.busy, busy_res);
            mismatches++;
          end
          case (want.ev)
            EV_SELECT:  moves_started++;
            EV_RELEASE: moves_released++;
            EV_REJECT:  starts_refused++;
            default: ;
          endcase
          if (want.pin && !last_pin) step_pulses++;
          last_pin = want.pin;
        end
      end
      res_stall <= ($urandom_range(0, 99) < take_stall_pct);
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Run stopped by the watchdog after %0d cycles", cycle_count);
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    logic [4:0]         m;
    logic [2:0]         md;
    logic signed [16:0] cnt;
    logic [7:0]         tq;
    int unsigned        choice;
    int unsigned        random_from;
    int unsigned        stage;

    // Reset settings: ticks while idle and starts with no valid motor or step size.
    plan_pace(17, 75);
    plan_ticks(2);
    plan_beat(CMD_START, 5'd0, 3'd0, 17'sd1, 8'd0);
    plan_beat(CMD_START, 5'd25, 3'd2, 17'sd1, 8'd0);
    plan_beat(CMD_START, 5'd31, 3'd4, -17'sd1, 8'd255);
    plan_beat(CMD_START, 5'd3, 3'd5, 17'sd2, 8'd9);
    plan_beat(CMD_START, 5'd24, 3'd7, 17'sd2, 8'd9);

    // Short moves over every step size, both directions, both zero-count directions,
    // and a start that arrives while a move is running.
    plan_register(CFG_BASE_HALF, 3);
    plan_register(CFG_TORQUE_GAIN, 1);
    plan_register(CFG_SETTLE, 2);
    plan_move(5'd1, 3'd0, 17'sd2, 8'd0, 1'b0, 1'b0);
    plan_move(5'd24, 3'd4, -17'sd1, 8'd255, 1'b1, 1'b0);
    plan_move(5'd16, 3'd3, -17'sd2, 8'd2, 1'b0, 1'b0);
    plan_move(5'd9, 3'd1, 17'sd0, 8'd7, 1'b0, 1'b0);
    plan_move(5'd17, 3'd2, 17'sd1, 8'd0, 1'b0, 1'b0);
    plan_move(5'd8, 3'd0, 17'sd0, 8'd1, 1'b0, 1'b0);

    // A half period that shifts down to zero is stretched to one tick.
    plan_register(CFG_BASE_HALF, 0);
    plan_move(5'd2, 3'd2, 17'sd3, 8'd0, 1'b0, 1'b0);

    // Random part: mostly complete moves, plus refused starts, trimmed moves,
    // register changes and pauses until all results are back.
    random_from = planned_beats;
    stage = 0;
    while (planned_beats - random_from < RANDOM_BEATS) begin
      if (stage == 0 && planned_beats - random_from >= RANDOM_BEATS / 3) begin
        plan_pace(75, 17);
        stage = 1;
      end else if (stage == 1 && planned_beats - random_from >= 2 * RANDOM_BEATS / 3) begin
        plan_pace(0, 0);
        stage = 2;
      end
      choice = $urandom_range(0, 99);
      m = 5'($urandom_range(1, MOTORS));
      md = 3'($urandom_range(0, 4));
      cnt = 17'(int'($urandom_range(0, 6)) - 3);
      tq = (plan_gain == 0) ? 8'($urandom) : 8'($urandom_range(0, 7));
      if (choice < 70) begin
        plan_move(m, md, cnt, tq, $urandom_range(0, 5) == 0, 1'b0);
      end else if (choice < 82) begin
        repeat ($urandom_range(1, 4)) begin
          if ($urandom_range(0, 1) == 0) begin
            plan_ticks(1);
          end else begin
            m = 5'($urandom);
            md = 3'($urandom);
            if (m >= 5'd1 && m <= MOTORS && md <= MODE_MAX) m = 5'd0;
            plan_beat(CMD_START, m, md, 17'($urandom), 8'($urandom));
          end
        end
      end else if (choice < 92) begin
        if ($urandom_range(0, 1) == 0) plan_register(CFG_BASE_HALF, $urandom_range(0, 16));
        if ($urandom_range(0, 1) == 0) plan_register(CFG_TORQUE_GAIN, $urandom_range(0, 3));
        plan_register(CFG_SETTLE, $urandom_range(0, 12));
      end else if (choice < 96) begin
        plan_drain();
      end else begin
        plan_move(m, md, cnt, tq, 1'b0, 1'b1);
      end
    end

    // Enough ticks to finish the longest move that the random part can leave running.
    plan_pace(0, 0);
    plan_ticks(236);

    // A saturating step count with a one-tick half period, cut short after a run of
    // pulses; a second start in the middle of it is refused as busy.
    plan_register(CFG_BASE_HALF, 0);
    plan_register(CFG_TORQUE_GAIN, 0);
    plan_register(CFG_SETTLE, 0);
    plan_beat(CMD_START, 5'd3, 3'd0, 17'h10000, 8'd0);
    plan_ticks(40);
    plan_beat(CMD_START, 5'd20, 3'd0, 17'sd65535, 8'd0);
    plan_ticks(8);

    // Register extremes written while that move keeps pulsing: refused starts and ticks follow.
    plan_register(CFG_BASE_HALF, 16'hFFFF);
    plan_register(CFG_TORQUE_GAIN, 10'h3FF);
    plan_register(CFG_SETTLE, 20'hFFFFF);
    repeat (6) begin
      plan_beat(CMD_START, 5'd0, 3'($urandom), 17'($urandom), 8'($urandom));
      plan_ticks(2);
    end

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    while (!plan_exhausted) @(posedge clk);
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Checked %0d result beats: %0d moves started, %0d released, %0d starts refused,",
             checked_beats, moves_started, moves_released, starts_refused);
    $display("%0d step pulses, under three stall patterns and register extremes.", step_pulses);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
